>>> design/spcol_pkg.sv
// Shared widths, payload types and the square-root step for the sprite pair
// collision test.
// No dependencies.
package spcol_pkg;

    localparam int COORD_W   = 16;              // signed centre coordinate
    localparam int SIZE_W    = 12;              // width or height
    localparam int RAD_W     = 20;              // radius, unsigned 16.4
    localparam int FRAC_BITS = 4;
    localparam int HALF_W    = SIZE_W - 1;      // truncated half size
    localparam int EDGE_W    = COORD_W + 1;     // box edge, signed, never wraps
    localparam int DIST_W    = COORD_W;         // |dx|, |dy|
    localparam int PROD_W    = 2 * DIST_W;      // dx^2
    localparam int DSQ_W     = PROD_W + 1;      // dx^2 + dy^2
    localparam int HPROD_W   = 2 * HALF_W;      // half size squared
    localparam int HSQ_W     = HPROD_W + 1;     // sum of squared halves
    localparam int SQ_IN_W   = 32;              // root operand, even width
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_STEPS  = 4;               // root bits per stage
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
    localparam int RSUM_W    = RAD_W + 1;
    localparam int RSQ_W     = 2 * RSUM_W;

    // Side data that travels next to the root pipeline.
    typedef struct packed {
        logic               use_circle;
        logic               box_hit;
        logic [DSQ_W-1:0]   dist_sq;
        logic [RAD_W-1:0]   first_radius;
        logic [RAD_W-1:0]   second_radius;
    } side_t;

    // Digit-by-digit root state: partial remainder, root so far, operand
    // bits not yet consumed (top two consumed first).
    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [SQ_IN_W-1:0] rest;
    } sq_state_t;

    function automatic sq_state_t sqrt_step(input sq_state_t s);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        sq_state_t        r;
        cur   = {s.rem, s.rest[SQ_IN_W-1 -: 2]};
        trial = (REM_W + 2)'({s.root, 2'b01});
        r.rest = {s.rest[SQ_IN_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = REM_W'(cur - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(cur);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> design/spcol_if.sv
// Valid/ready channel interfaces for sprite pair transactions and collide
// results. Depends on spcol_pkg.
interface spcol_in_if;
    import spcol_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       use_circle;
    logic signed [COORD_W-1:0]  first_x;
    logic signed [COORD_W-1:0]  first_y;
    logic [SIZE_W-1:0]          first_width;
    logic [SIZE_W-1:0]          first_height;
    logic [RAD_W-1:0]           first_radius;
    logic signed [COORD_W-1:0]  second_x;
    logic signed [COORD_W-1:0]  second_y;
    logic [SIZE_W-1:0]          second_width;
    logic [SIZE_W-1:0]          second_height;
    logic [RAD_W-1:0]           second_radius;

    modport source (
        output valid, use_circle, first_x, first_y, first_width, first_height,
               first_radius, second_x, second_y, second_width, second_height,
               second_radius,
        input  ready
    );

    modport sink (
        input  valid, use_circle, first_x, first_y, first_width, first_height,
               first_radius, second_x, second_y, second_width, second_height,
               second_radius,
        output ready
    );
endinterface

interface spcol_out_if;
    logic valid;
    logic ready;
    logic collide;

    modport source (output valid, collide, input ready);
    modport sink   (input valid, collide, output ready);
endinterface

>>> design/spcol_front.sv
// First three pipeline stages: distances, box corner test, squares and sums.
// Depends on spcol_pkg and spcol_if.
module spcol_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    spcol_in_if.sink                     req,
    output logic                         valid,
    output spcol_pkg::side_t             side,
    output logic [spcol_pkg::HSQ_W-1:0]  first_sq,
    output logic [spcol_pkg::HSQ_W-1:0]  second_sq
);
    import spcol_pkg::*;

    // stage 1
    logic                       s1_valid_reg;
    logic                       s1_circle_reg;
    logic [DIST_W-1:0]          s1_ux_reg, s1_uy_reg;
    logic [HALF_W-1:0]          s1_ahw_reg, s1_ahh_reg, s1_bhw_reg, s1_bhh_reg;
    logic signed [EDGE_W-1:0]   s1_x0_reg, s1_x1_reg, s1_y0_reg, s1_y1_reg;
    logic signed [EDGE_W-1:0]   s1_bxl_reg, s1_bxh_reg, s1_byl_reg, s1_byh_reg;
    logic [RAD_W-1:0]           s1_ra_reg, s1_rb_reg;

    logic signed [EDGE_W-1:0]   ax, ay, bx, by, dx, dy;
    logic signed [EDGE_W-1:0]   ahw_e, ahh_e, bhw_e, bhh_e;
    logic [HALF_W-1:0]          ahw, ahh, bhw, bhh;

    // stage 2
    logic                       s2_valid_reg;
    logic                       s2_circle_reg;
    logic                       s2_box_reg;
    logic [PROD_W-1:0]          s2_ux2_reg, s2_uy2_reg;
    logic [HPROD_W-1:0]         s2_ahw2_reg, s2_ahh2_reg, s2_bhw2_reg, s2_bhh2_reg;
    logic [RAD_W-1:0]           s2_ra_reg, s2_rb_reg;

    logic                       in_x0, in_x1, in_y0, in_y1;

    // stage 3
    logic                       s3_valid_reg;
    side_t                      s3_side_reg;
    logic [HSQ_W-1:0]           s3_asq_reg, s3_bsq_reg;

    always_comb
    begin
        ax = {req.first_x[COORD_W-1], req.first_x};
        ay = {req.first_y[COORD_W-1], req.first_y};
        bx = {req.second_x[COORD_W-1], req.second_x};
        by = {req.second_y[COORD_W-1], req.second_y};
        dx = ax - bx;
        dy = ay - by;
        ahw = req.first_width[SIZE_W-1:1];
        ahh = req.first_height[SIZE_W-1:1];
        bhw = req.second_width[SIZE_W-1:1];
        bhh = req.second_height[SIZE_W-1:1];
        ahw_e = {{(EDGE_W-HALF_W){1'b0}}, ahw};
        ahh_e = {{(EDGE_W-HALF_W){1'b0}}, ahh};
        bhw_e = {{(EDGE_W-HALF_W){1'b0}}, bhw};
        bhh_e = {{(EDGE_W-HALF_W){1'b0}}, bhh};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_circle_reg <= req.use_circle;
            s1_ux_reg  <= dx[EDGE_W-1] ? DIST_W'(-dx) : DIST_W'(dx);
            s1_uy_reg  <= dy[EDGE_W-1] ? DIST_W'(-dy) : DIST_W'(dy);
            s1_ahw_reg <= ahw;
            s1_ahh_reg <= ahh;
            s1_bhw_reg <= bhw;
            s1_bhh_reg <= bhh;
            s1_x0_reg  <= ax - ahw_e;
            s1_x1_reg  <= ax + ahw_e;
            s1_y0_reg  <= ay - ahh_e;
            s1_y1_reg  <= ay + ahh_e;
            s1_bxl_reg <= bx - bhw_e;
            s1_bxh_reg <= bx + bhw_e;
            s1_byl_reg <= by - bhh_e;
            s1_byh_reg <= by + bhh_e;
            s1_ra_reg  <= req.first_radius;
            s1_rb_reg  <= req.second_radius;
        end
    end

    // Corner test: any corner inside means some x edge and some y edge inside.
    always_comb
    begin
        in_x0 = (s1_x0_reg >= s1_bxl_reg) && (s1_x0_reg <= s1_bxh_reg);
        in_x1 = (s1_x1_reg >= s1_bxl_reg) && (s1_x1_reg <= s1_bxh_reg);
        in_y0 = (s1_y0_reg >= s1_byl_reg) && (s1_y0_reg <= s1_byh_reg);
        in_y1 = (s1_y1_reg >= s1_byl_reg) && (s1_y1_reg <= s1_byh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_circle_reg <= s1_circle_reg;
            s2_box_reg    <= (in_x0 || in_x1) && (in_y0 || in_y1);
            s2_ux2_reg    <= PROD_W'(s1_ux_reg) * PROD_W'(s1_ux_reg);
            s2_uy2_reg    <= PROD_W'(s1_uy_reg) * PROD_W'(s1_uy_reg);
            s2_ahw2_reg   <= HPROD_W'(s1_ahw_reg) * HPROD_W'(s1_ahw_reg);
            s2_ahh2_reg   <= HPROD_W'(s1_ahh_reg) * HPROD_W'(s1_ahh_reg);
            s2_bhw2_reg   <= HPROD_W'(s1_bhw_reg) * HPROD_W'(s1_bhw_reg);
            s2_bhh2_reg   <= HPROD_W'(s1_bhh_reg) * HPROD_W'(s1_bhh_reg);
            s2_ra_reg     <= s1_ra_reg;
            s2_rb_reg     <= s1_rb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg.use_circle    <= s2_circle_reg;
            s3_side_reg.box_hit       <= s2_box_reg;
            s3_side_reg.dist_sq       <= DSQ_W'(s2_ux2_reg) + DSQ_W'(s2_uy2_reg);
            s3_side_reg.first_radius  <= s2_ra_reg;
            s3_side_reg.second_radius <= s2_rb_reg;
            s3_asq_reg <= HSQ_W'(s2_ahw2_reg) + HSQ_W'(s2_ahh2_reg);
            s3_bsq_reg <= HSQ_W'(s2_bhw2_reg) + HSQ_W'(s2_bhh2_reg);
        end
    end

    assign valid     = s3_valid_reg;
    assign side      = s3_side_reg;
    assign first_sq  = s3_asq_reg;
    assign second_sq = s3_bsq_reg;

endmodule

>>> design/spcol_sqrt.sv
// Pipelined integer square root, a fixed number of root bits per stage.
// Depends on spcol_pkg.
module spcol_sqrt (
    input  logic                            clk,
    input  logic                            adv,
    input  logic [spcol_pkg::SQ_IN_W-1:0]   operand,
    output logic [spcol_pkg::ROOT_W-1:0]    root
);
    import spcol_pkg::*;

    sq_state_t st_reg  [SQ_STAGES];
    sq_state_t st_next [SQ_STAGES];

    genvar g;
    generate
        for (g = 0; g < SQ_STAGES; g++)
        begin : g_stage
            always_comb
            begin
                sq_state_t s;
                if (g == 0)
                begin
                    s.rem  = '0;
                    s.root = '0;
                    s.rest = operand;
                end
                else
                begin
                    s = st_reg[(g == 0) ? 0 : g - 1];
                end
                for (int k = 0; k < SQ_STEPS; k++)
                begin
                    s = sqrt_step(s);
                end
                st_next[g] = s;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_reg[g] <= st_next[g];
                end
            end
        end
    endgenerate

    assign root = st_reg[SQ_STAGES-1].root;

endmodule

>>> design/spcol_back.sv
// Last three pipeline stages: radius pick and sum, squaring, final compare
// and the result register. Depends on spcol_pkg and spcol_if.
module spcol_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid,
    input  spcol_pkg::side_t              side,
    input  logic [spcol_pkg::ROOT_W-1:0]  first_root,
    input  logic [spcol_pkg::ROOT_W-1:0]  second_root,
    spcol_out_if.source                   rsp
);
    import spcol_pkg::*;

    logic                   b1_valid_reg, b2_valid_reg, out_valid_reg;
    logic                   b1_circle_reg, b2_circle_reg;
    logic                   b1_box_reg, b2_box_reg;
    logic [DSQ_W-1:0]       b1_dist_reg, b2_dist_reg;
    logic [RSUM_W-1:0]      b1_rsum_reg;
    logic [RSQ_W-1:0]       b2_rsq_reg;
    logic                   collide_reg;

    logic [RAD_W-1:0]       ra, rb;
    logic [RSQ_W-1:0]       dist_scaled;

    // Zero radius falls back to the root of the squared half sizes.
    always_comb
    begin
        ra = (side.first_radius != '0) ? side.first_radius
                                       : RAD_W'(first_root);
        rb = (side.second_radius != '0) ? side.second_radius
                                        : RAD_W'(second_root);
        dist_scaled = RSQ_W'({b2_dist_reg, {(2*FRAC_BITS){1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_circle_reg <= side.use_circle;
            b1_box_reg    <= side.box_hit;
            b1_dist_reg   <= side.dist_sq;
            b1_rsum_reg   <= RSUM_W'(ra) + RSUM_W'(rb);

            b2_circle_reg <= b1_circle_reg;
            b2_box_reg    <= b1_box_reg;
            b2_dist_reg   <= b1_dist_reg;
            b2_rsq_reg    <= RSQ_W'(b1_rsum_reg) * RSQ_W'(b1_rsum_reg);

            collide_reg   <= b2_circle_reg ? (dist_scaled <= b2_rsq_reg)
                                           : b2_box_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.collide = collide_reg;

endmodule

>>> design/sprite_pair_collision_test_top.sv
// Sprite pair collision test, top level. Depends on spcol_pkg, spcol_if,
// spcol_front, spcol_sqrt and spcol_back.
//
// Each request transaction carries two sprites (centre, size, optional
// 16.4 radius) and a mode bit; each response transaction carries one collide
// flag, in request order. Circle mode compares the squared centre distance,
// scaled to 1/16 pixel, against the squared sum of the radii; a zero radius
// is replaced by the truncated root of the squared integer half sizes.
// Box mode reports a hit when any corner of the first box lies inclusively
// inside the second box (corners only: a cross-shaped overlap is a miss).
// The datapath is a ten-stage pipeline: three front stages (distances and
// box edges, corner compare and squares, sums of squares), four root stages
// of four result bits each, then radius sum, squaring and the compare into
// the response register. A new request is taken every cycle while the
// response side keeps up. The whole pipeline holds while a response is
// shown and not taken, so nothing is dropped or repeated.
// There is no configuration and no state beyond the pipeline itself.
module sprite_pair_collision_test_top (
    input  logic         clk,
    input  logic         rst_n,
    spcol_in_if.sink     req,
    spcol_out_if.source  rsp
);
    import spcol_pkg::*;

    logic                   adv;
    logic                   front_valid;
    side_t                  front_side;
    logic [HSQ_W-1:0]       first_sq, second_sq;
    logic [ROOT_W-1:0]      first_root, second_root;

    // side line alongside the root stages
    logic [SQ_STAGES-1:0]   line_valid_reg;
    side_t                  line_reg [SQ_STAGES];

    // Advance when the response register is empty or being taken.
    assign adv       = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    spcol_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req       (req),
        .valid     (front_valid),
        .side      (front_side),
        .first_sq  (first_sq),
        .second_sq (second_sq)
    );

    // operand = (hw^2 + hh^2) << 8, zero padded to an even width
    spcol_sqrt u_sqrt_first (
        .clk     (clk),
        .adv     (adv),
        .operand (SQ_IN_W'({first_sq, {(2*FRAC_BITS){1'b0}}})),
        .root    (first_root)
    );

    spcol_sqrt u_sqrt_second (
        .clk     (clk),
        .adv     (adv),
        .operand (SQ_IN_W'({second_sq, {(2*FRAC_BITS){1'b0}}})),
        .root    (second_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
        end
        else if (adv)
        begin
            line_valid_reg <= {line_valid_reg[SQ_STAGES-2:0], front_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_reg[0] <= front_side;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    spcol_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid       (line_valid_reg[SQ_STAGES-1]),
        .side        (line_reg[SQ_STAGES-1]),
        .first_root  (first_root),
        .second_root (second_root),
        .rsp         (rsp)
    );

endmodule

>>> verif/tb_sprite_pair_collision_test_top.sv
// Self-checking testbench for sprite_pair_collision_test_top: directed table and
// randomised sprite pairs, checked against a behavioural collide predictor.
// Depends on spcol_pkg, spcol_if and the design under test.
module tb_sprite_pair_collision_test_top;
    import spcol_pkg::*;

    localparam int N_RANDOM  = 1250;
    localparam int TAIL_WAIT = 16;      // pipeline is ten deep; allow margin

    // How a table row gets its expected flag: typed in, or from the predictor.
    typedef enum logic [1:0] {
        VERDICT_PREDICT,
        VERDICT_HIT,
        VERDICT_MISS
    } verdict_e;

    // Receiver behaviour, picked afresh at random from time to time.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_TRICKLE
    } sink_mode_e;

    typedef struct packed {
        logic                       use_circle;
        logic signed [COORD_W-1:0]  first_x;
        logic signed [COORD_W-1:0]  first_y;
        logic [SIZE_W-1:0]          first_width;
        logic [SIZE_W-1:0]          first_height;
        logic [RAD_W-1:0]           first_radius;
        logic signed [COORD_W-1:0]  second_x;
        logic signed [COORD_W-1:0]  second_y;
        logic [SIZE_W-1:0]          second_width;
        logic [SIZE_W-1:0]          second_height;
        logic [RAD_W-1:0]           second_radius;
    } sprite_pair_t;

    typedef struct packed {
        sprite_pair_t   pair;
        verdict_e       verdict;
    } pair_row_t;

    logic clk;
    logic rst_n;

    spcol_in_if  req_if ();
    spcol_out_if rsp_if ();

    // Collide flags owed by the block, oldest first.
    logic collide_due[$];
    int   error_count = 0;

    sprite_pair_collision_test_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Single reset, released on a falling edge well clear of the sampling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Radius in 16.4 fixed point; zero means the truncated root of the squared
    // integer half sizes, scaled by 256 so the root lands on 1/16 pixel.
    function automatic longint unsigned radius_of(logic [RAD_W-1:0] radius,
                                                  logic [SIZE_W-1:0] w,
                                                  logic [SIZE_W-1:0] h);
        longint unsigned hw;
        longint unsigned hh;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        if (radius != '0)
            return radius;
        hw = w / 2;
        hh = h / 2;
        sq = (hw * hw + hh * hh) << (2 * FRAC_BITS);
        // operand stays below 2^32, so the root needs at most 17 bits
        root = 0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic collide_of(sprite_pair_t p);
        longint          ax;
        longint          ay;
        longint          bx;
        longint          by;
        longint          ux;
        longint          uy;
        longint          ahw;
        longint          ahh;
        longint          bhw;
        longint          bhh;
        longint          px;
        longint          py;
        longint unsigned dist_sq;
        longint unsigned rad_sum;
        logic            hit;
        ax = p.first_x;
        ay = p.first_y;
        bx = p.second_x;
        by = p.second_y;
        hit = 1'b0;
        if (p.use_circle)
        begin
            ux = ax - bx;
            uy = ay - by;
            if (ux < 0)
                ux = -ux;
            if (uy < 0)
                uy = -uy;
            dist_sq = ux * ux + uy * uy;
            dist_sq = dist_sq << (2 * FRAC_BITS);
            rad_sum = radius_of(p.first_radius, p.first_width, p.first_height)
                    + radius_of(p.second_radius, p.second_width, p.second_height);
            hit = (dist_sq <= rad_sum * rad_sum);
        end
        else
        begin
            ahw = p.first_width / 2;
            ahh = p.first_height / 2;
            bhw = p.second_width / 2;
            bhh = p.second_height / 2;
            // corners of the first box only, against the second box inclusive
            for (int c = 0; c < 4; c++)
            begin
                px = c[0] ? ax + ahw : ax - ahw;
                py = c[1] ? ay + ahh : ay - ahh;
                if (px >= bx - bhw && px <= bx + bhw && py >= by - bhh && py <= by + bhh)
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic pair_row_t dir_row(verdict_e v, logic circle,
                                          int ax, int ay, int aw, int ah, int ar,
                                          int bx, int by, int bw, int bh, int br);
        pair_row_t r;
        r.verdict              = v;
        r.pair.use_circle      = circle;
        r.pair.first_x         = COORD_W'(ax);
        r.pair.first_y         = COORD_W'(ay);
        r.pair.first_width     = SIZE_W'(aw);
        r.pair.first_height    = SIZE_W'(ah);
        r.pair.first_radius    = RAD_W'(ar);
        r.pair.second_x        = COORD_W'(bx);
        r.pair.second_y        = COORD_W'(by);
        r.pair.second_width    = SIZE_W'(bw);
        r.pair.second_height   = SIZE_W'(bh);
        r.pair.second_radius   = RAD_W'(br);
        return r;
    endfunction

    // Mostly small sprites, now and then anything up to the full field.
    function automatic logic [SIZE_W-1:0] random_size();
        if ($urandom_range(0, 7) == 0)
            return SIZE_W'($urandom);
        return SIZE_W'($urandom_range(0, 128));
    endfunction

    // Half derived from size, the rest explicit: small or anywhere in 16.4.
    function automatic logic [RAD_W-1:0] random_radius();
        case ($urandom_range(0, 3))
            0, 1: return '0;
            2: return RAD_W'($urandom_range(1, 2400));
            default: return RAD_W'($urandom);
        endcase
    endfunction

    // Second sprite usually placed near the first so hits and near misses
    // both turn up; one pair in four is spread over the whole plane.
    function automatic sprite_pair_t random_pair();
        sprite_pair_t p;
        int           spread;
        p.use_circle    = 1'($urandom_range(0, 1));
        p.first_x       = COORD_W'($urandom);
        p.first_y       = COORD_W'($urandom);
        p.first_width   = random_size();
        p.first_height  = random_size();
        p.first_radius  = random_radius();
        p.second_width  = random_size();
        p.second_height = random_size();
        p.second_radius = random_radius();
        if ($urandom_range(0, 3) == 0)
        begin
            p.second_x = COORD_W'($urandom);
            p.second_y = COORD_W'($urandom);
        end
        else
        begin
            spread     = $urandom_range(1, 200);
            p.second_x = COORD_W'(int'(p.first_x) + $urandom_range(0, 2 * spread) - spread);
            p.second_y = COORD_W'(int'(p.first_y) + $urandom_range(0, 2 * spread) - spread);
        end
        return p;
    endfunction

    // Request side: bursts of back-to-back transactions separated by random
    // gaps. All changes happen on the falling edge; acceptance is seen on
    // the rising edge, where the expected flag is queued.
    initial
    begin : pair_source
        pair_row_t stimulus[$];
        pair_row_t row;
        int        burst_left;
        int        gap;

        req_if.valid         = 1'b0;
        req_if.use_circle    = 1'b0;
        req_if.first_x       = '0;
        req_if.first_y       = '0;
        req_if.first_width   = '0;
        req_if.first_height  = '0;
        req_if.first_radius  = '0;
        req_if.second_x      = '0;
        req_if.second_y      = '0;
        req_if.second_width  = '0;
        req_if.second_height = '0;
        req_if.second_radius = '0;
        burst_left           = 0;

        //                           mode  ax      ay      aw    ah    ar
        //                                 bx      by      bw    bh    br
        // circle: coincident points with zero size and radius touch
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b1, 0, 0, 0, 0, 0,
                                   0, 0, 0, 0, 0));
        // circle: opposite corners of the plane, largest radii still reach
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b1, -32768, -32768, 0, 0, 1048575,
                                   32767, 32767, 0, 0, 1048575));
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b1, -32768, -32768, 0, 0, 1,
                                   32767, 32767, 0, 0, 1));
        // circle: largest derived radii are far too small for that distance
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b1, -32768, -32768, 4095, 4095, 0,
                                   32767, 32767, 4095, 4095, 0));
        // circle: distance equal to the radius sum is a hit, one more is not
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b1, 0, 0, 0, 0, 80,
                                   10, 0, 0, 0, 80));
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b1, 0, 0, 0, 0, 80,
                                   11, 0, 0, 0, 80));
        // circle: derived 3-4-5 radius, exact touch and just apart
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b1, 0, 0, 6, 8, 0,
                                   0, 10, 6, 8, 0));
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b1, 0, 0, 6, 8, 0,
                                   0, -11, 6, 8, 0));
        // circle: odd sizes use truncated halves
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b1, -3, -4, 7, 9, 0,
                                   3, 4, 6, 8, 0));
        // circle: derived root that is not a whole 1/16 pixel
        stimulus.push_back(dir_row(VERDICT_PREDICT, 1'b1, 0, 0, 2, 2, 0,
                                   2, 2, 2, 2, 0));
        stimulus.push_back(dir_row(VERDICT_PREDICT, 1'b1, 0, 0, 2, 2, 0,
                                   2, 1, 2, 2, 0));
        // circle: one explicit radius, one derived
        stimulus.push_back(dir_row(VERDICT_PREDICT, 1'b1, 100, -50, 40, 10, 333,
                                   130, -20, 17, 33, 0));
        // circle: unit sizes have zero halves, so a zero radius
        stimulus.push_back(dir_row(VERDICT_PREDICT, 1'b1, 1, 1, 1, 1, 0,
                                   1, 1, 1, 1, 0));
        // box: identical boxes, radius fields ignored
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b0, 5, 5, 10, 10, 1048575,
                                   5, 5, 10, 10, 1));
        // box: first box wholly inside the second
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b0, 0, 0, 4, 4, 0,
                                   1, 1, 20, 20, 0));
        // box: cross-shaped overlap, no corner inside, so a miss
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b0, 0, 0, 20, 2, 0,
                                   0, 0, 2, 20, 0));
        // box: second inside first, corners of the first all outside
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b0, 0, 0, 40, 40, 0,
                                   0, 0, 4, 4, 0));
        // box: corner exactly on the edge, then one pixel clear
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b0, 0, 0, 10, 10, 0,
                                   10, 10, 10, 10, 0));
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b0, 0, 0, 10, 10, 0,
                                   11, 11, 10, 10, 0));
        // box: zero sizes, same point and neighbouring points
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b0, -7, 3, 0, 0, 0,
                                   -7, 3, 0, 0, 0));
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b0, -7, 3, 0, 0, 0,
                                   -7, 4, 0, 0, 0));
        // box: edges past the coordinate range must not wrap round
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b0, 32767, 32767, 4094, 4094, 0,
                                   -32768, -32768, 4095, 4095, 0));
        stimulus.push_back(dir_row(VERDICT_HIT, 1'b0, -32768, -32768, 4095, 4095, 0,
                                   -32768, -32768, 4095, 4095, 0));
        // box: odd width truncates the half, so the corner falls short
        stimulus.push_back(dir_row(VERDICT_MISS, 1'b0, 0, 0, 11, 1, 0,
                                   8, 0, 5, 1, 0));
        stimulus.push_back(dir_row(VERDICT_PREDICT, 1'b0, -100, 50, 30, 17, 1048575,
                                   -90, 60, 25, 9, 1048575));

        repeat (N_RANDOM)
        begin
            row.pair    = random_pair();
            row.verdict = VERDICT_PREDICT;
            stimulus.push_back(row);
        end

        wait (rst_n === 1'b1);
        @(negedge clk);

        foreach (stimulus[i])
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            req_if.valid         <= 1'b1;
            req_if.use_circle    <= stimulus[i].pair.use_circle;
            req_if.first_x       <= stimulus[i].pair.first_x;
            req_if.first_y       <= stimulus[i].pair.first_y;
            req_if.first_width   <= stimulus[i].pair.first_width;
            req_if.first_height  <= stimulus[i].pair.first_height;
            req_if.first_radius  <= stimulus[i].pair.first_radius;
            req_if.second_x      <= stimulus[i].pair.second_x;
            req_if.second_y      <= stimulus[i].pair.second_y;
            req_if.second_width  <= stimulus[i].pair.second_width;
            req_if.second_height <= stimulus[i].pair.second_height;
            req_if.second_radius <= stimulus[i].pair.second_radius;

            @(posedge clk);
            while (req_if.ready !== 1'b1)
                @(posedge clk);

            case (stimulus[i].verdict)
                VERDICT_HIT:  collide_due.push_back(1'b1);
                VERDICT_MISS: collide_due.push_back(1'b0);
                default:      collide_due.push_back(collide_of(stimulus[i].pair));
            endcase
            burst_left--;
            @(negedge clk);
        end
        req_if.valid <= 1'b0;

        // drain, then give stray responses a chance to show themselves
        while (collide_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Response side: ready follows a pattern of its own, switching between
    // always open, coin-toss and a periodic trickle.
    initial
    begin : result_sink
        sink_mode_e mode;
        int         mode_left;

        rsp_if.ready = 1'b0;
        mode         = SINK_OPEN;
        mode_left    = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = sink_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
                SINK_OPEN: rsp_if.ready <= 1'b1;
                SINK_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
                default:   rsp_if.ready <= (mode_left % 8 == 0);
            endcase
        end
    end

    // Each response transaction is matched against the oldest owed flag.
    always @(posedge clk)
    begin : collide_check
        logic want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (collide_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected response, expected none, actual collide=%0b",
                         $time, rsp_if.collide);
            end
            else
            begin
                want = collide_due.pop_front();
                if (rsp_if.collide !== want)
                begin
                    error_count++;
                    $display("%0t: collide mismatch, expected %0b, actual %0b",
                             $time, want, rsp_if.collide);
                end
            end
        end
    end

    // Watchdog: roughly ten times the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
